// ----- sv/heap_free_coalesce_assert.svh -----
// assertion helpers, clocked on clock and disabled during reset
`ifndef HEAP_FREE_COALESCE_ASSERT_SVH
`define HEAP_FREE_COALESCE_ASSERT_SVH

// same-cycle implication
`define HFC_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HFC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/hfc_pkg.sv -----
`timescale 1ns / 1ps

package hfc_pkg;

   localparam int HEAP_WORDS = 4096;
   localparam int TAG_BYTES  = 8;
   localparam int WORD_AW    = $clog2(HEAP_WORDS);
   localparam int OFF_W      = 15;
   localparam int PC_W       = 5;

   localparam logic [63:0] SIZE_MASK = ~64'hF;

   typedef struct packed {
      logic [1:0]       operation;
      logic [OFF_W-1:0] address;
      logic [63:0]      data;
   } req_type;

   typedef struct packed {
      logic [63:0]      read_data;
      logic             status;
      logic [OFF_W-1:0] merged_block_offset;
      logic [15:0]      merged_block_size;
   } rsp_type;

   typedef enum logic [1:0] {
      OPER_WRITE = 2'd0,
      OPER_READ  = 2'd1,
      OPER_FREE  = 2'd2
   } oper_type;

   typedef enum logic [1:0] {
      ASEL_BLK,
      ASEL_AUX,
      ASEL_FOOT,
      ASEL_PFOOT
   } addr_sel_type;

   typedef enum logic [2:0] {
      WSEL_DATA,
      WSEL_CLR_ALLOC,
      WSEL_SIZE,
      WSEL_TAG_RD,
      WSEL_TAG_PREV,
      WSEL_CLR_PREV
   } wd_sel_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD_SIZE,
      OP_NEXT_PTR,
      OP_ADD_NEXT,
      OP_PREV_PTR,
      OP_LOAD_PREV,
      OP_MERGE_PREV,
      OP_FINAL_PTR
   } dp_op_type;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_NULL,
      COND_FREE,
      COND_ALLOC,
      COND_NO_BACK
   } cond_type;

   typedef enum logic [2:0] {
      FIN_NONE,
      FIN_ZERO,
      FIN_READ,
      FIN_IGNORE,
      FIN_FREE
   } fin_type;

   typedef struct packed {
      logic              rd;
      logic              wr;
      addr_sel_type      asel;
      wd_sel_type        wsel;
      dp_op_type         op;
      cond_type          cond;
      logic [PC_W-1:0]   target;
      fin_type           fin;
   } uword_type;

   // control from sequencer to datapath; rd, wr, op and fin already gated by branch outcome
   typedef struct packed {
      logic         load;
      logic         rd;
      logic         wr;
      addr_sel_type asel;
      wd_sel_type   wsel;
      dp_op_type    op;
      fin_type      fin;
   } ctrl_type;

   typedef struct packed {
      logic null_addr;
      logic alloc;
      logic no_back;
   } flags_type;

   // program entry points and branch targets
   localparam logic [PC_W-1:0] PC_WRITE  = PC_W'(0);
   localparam logic [PC_W-1:0] PC_READ   = PC_W'(1);
   localparam logic [PC_W-1:0] PC_NOP    = PC_W'(3);
   localparam logic [PC_W-1:0] PC_FREE   = PC_W'(4);
   localparam logic [PC_W-1:0] PC_PREV   = PC_W'(14);
   localparam logic [PC_W-1:0] PC_FINAL  = PC_W'(22);
   localparam logic [PC_W-1:0] PC_IGNORE = PC_W'(26);

   function automatic logic [WORD_AW-1:0] word_index(input logic [OFF_W-1:0] off);
      logic [WORD_AW+OFF_W-1:0] w;
      w = {{WORD_AW{1'b0}}, off} >> 3;
      return w[WORD_AW-1:0];
   endfunction

   function automatic uword_type mk_uword(input logic rd, input logic wr,
                                          input addr_sel_type asel, input wd_sel_type wsel,
                                          input dp_op_type op, input cond_type cond,
                                          input logic [PC_W-1:0] target, input fin_type fin);
      uword_type u;
      u.rd     = rd;
      u.wr     = wr;
      u.asel   = asel;
      u.wsel   = wsel;
      u.op     = op;
      u.cond   = cond;
      u.target = target;
      u.fin    = fin;
      return u;
   endfunction

   function automatic uword_type ucode_rom(input logic [PC_W-1:0] pc);
      uword_type u;
      case (pc)
         // write word
         5'd0: u = mk_uword(1'b0, 1'b1, ASEL_AUX, WSEL_DATA, OP_NONE, COND_NONE, PC_WRITE,
                            FIN_ZERO);
         // read word
         5'd1: u = mk_uword(1'b1, 1'b0, ASEL_AUX, WSEL_DATA, OP_NONE, COND_NONE, PC_WRITE,
                            FIN_NONE);
         5'd2: u = mk_uword(1'b0, 1'b0, ASEL_AUX, WSEL_DATA, OP_NONE, COND_NONE, PC_WRITE,
                            FIN_READ);
         // unused code
         5'd3: u = mk_uword(1'b0, 1'b0, ASEL_AUX, WSEL_DATA, OP_NONE, COND_NONE, PC_WRITE,
                            FIN_ZERO);
         // free: fetch header, mark free, write footer
         5'd4: u = mk_uword(1'b1, 1'b0, ASEL_BLK, WSEL_DATA, OP_NONE, COND_NULL, PC_IGNORE,
                            FIN_NONE);
         5'd5: u = mk_uword(1'b0, 1'b0, ASEL_BLK, WSEL_DATA, OP_LOAD_SIZE, COND_FREE,
                            PC_IGNORE, FIN_NONE);
         5'd6: u = mk_uword(1'b0, 1'b1, ASEL_BLK, WSEL_CLR_ALLOC, OP_NONE, COND_NONE,
                            PC_WRITE, FIN_NONE);
         5'd7: u = mk_uword(1'b0, 1'b1, ASEL_FOOT, WSEL_SIZE, OP_NONE, COND_NONE, PC_WRITE,
                            FIN_NONE);
         // merge forward
         5'd8: u = mk_uword(1'b0, 1'b0, ASEL_BLK, WSEL_DATA, OP_NEXT_PTR, COND_NONE,
                            PC_WRITE, FIN_NONE);
         5'd9: u = mk_uword(1'b1, 1'b0, ASEL_AUX, WSEL_DATA, OP_NONE, COND_NONE, PC_WRITE,
                            FIN_NONE);
         5'd10: u = mk_uword(1'b0, 1'b0, ASEL_BLK, WSEL_DATA, OP_ADD_NEXT, COND_ALLOC,
                             PC_PREV, FIN_NONE);
         5'd11: u = mk_uword(1'b1, 1'b0, ASEL_BLK, WSEL_DATA, OP_NONE, COND_NONE, PC_WRITE,
                             FIN_NONE);
         5'd12: u = mk_uword(1'b0, 1'b1, ASEL_BLK, WSEL_TAG_RD, OP_NONE, COND_NONE,
                             PC_WRITE, FIN_NONE);
         5'd13: u = mk_uword(1'b0, 1'b1, ASEL_FOOT, WSEL_SIZE, OP_NONE, COND_NONE, PC_WRITE,
                             FIN_NONE);
         // merge backward
         5'd14: u = mk_uword(1'b1, 1'b0, ASEL_BLK, WSEL_DATA, OP_NONE, COND_NONE, PC_WRITE,
                             FIN_NONE);
         5'd15: u = mk_uword(1'b1, 1'b0, ASEL_PFOOT, WSEL_DATA, OP_NONE, COND_NO_BACK,
                             PC_FINAL, FIN_NONE);
         5'd16: u = mk_uword(1'b0, 1'b0, ASEL_BLK, WSEL_DATA, OP_PREV_PTR, COND_NONE,
                             PC_WRITE, FIN_NONE);
         5'd17: u = mk_uword(1'b1, 1'b0, ASEL_AUX, WSEL_DATA, OP_NONE, COND_NONE, PC_WRITE,
                             FIN_NONE);
         5'd18: u = mk_uword(1'b1, 1'b0, ASEL_BLK, WSEL_DATA, OP_LOAD_PREV, COND_NONE,
                             PC_WRITE, FIN_NONE);
         5'd19: u = mk_uword(1'b0, 1'b0, ASEL_BLK, WSEL_DATA, OP_MERGE_PREV, COND_NONE,
                             PC_WRITE, FIN_NONE);
         5'd20: u = mk_uword(1'b0, 1'b1, ASEL_BLK, WSEL_TAG_PREV, OP_NONE, COND_NONE,
                             PC_WRITE, FIN_NONE);
         5'd21: u = mk_uword(1'b0, 1'b1, ASEL_FOOT, WSEL_SIZE, OP_NONE, COND_NONE, PC_WRITE,
                             FIN_NONE);
         // clear prev-allocated bit of the following block
         5'd22: u = mk_uword(1'b1, 1'b0, ASEL_BLK, WSEL_DATA, OP_NONE, COND_NONE, PC_WRITE,
                             FIN_NONE);
         5'd23: u = mk_uword(1'b0, 1'b0, ASEL_BLK, WSEL_DATA, OP_FINAL_PTR, COND_NONE,
                             PC_WRITE, FIN_NONE);
         5'd24: u = mk_uword(1'b1, 1'b0, ASEL_AUX, WSEL_DATA, OP_NONE, COND_NONE, PC_WRITE,
                             FIN_NONE);
         5'd25: u = mk_uword(1'b0, 1'b1, ASEL_AUX, WSEL_CLR_PREV, OP_NONE, COND_NONE,
                             PC_WRITE, FIN_FREE);
         5'd26: u = mk_uword(1'b0, 1'b0, ASEL_BLK, WSEL_DATA, OP_NONE, COND_NONE, PC_WRITE,
                             FIN_IGNORE);
         default: u = mk_uword(1'b0, 1'b0, ASEL_BLK, WSEL_DATA, OP_NONE, COND_NONE,
                               PC_WRITE, FIN_ZERO);
      endcase
      return u;
   endfunction

endpackage

// ----- sv/hfc_ram.sv -----
`timescale 1ns / 1ps

module hfc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/hfc_useq.sv -----
`timescale 1ns / 1ps
`include "heap_free_coalesce_assert.svh"

module hfc_useq (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [1:0]          operation,
   input  hfc_pkg::flags_type  flags,
   output hfc_pkg::ctrl_type   ctrl,
   output logic                busy
);

   logic [hfc_pkg::PC_W-1:0] pc_ff;
   logic [hfc_pkg::PC_W-1:0] pc_in;
   logic                     busy_ff;
   logic                     busy_in;
   hfc_pkg::uword_type       uw;
   logic                     jump;
   logic                     exec;
   logic                     load;
   logic [hfc_pkg::PC_W-1:0] entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= hfc_pkg::PC_NOP;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
      end
   end

   always_comb begin
      uw   = hfc_pkg::ucode_rom(pc_ff);
      load = start && !busy_ff;

      case (uw.cond)
         hfc_pkg::COND_NONE:    jump = 1'b0;
         hfc_pkg::COND_NULL:    jump = flags.null_addr;
         hfc_pkg::COND_FREE:    jump = !flags.alloc;
         hfc_pkg::COND_ALLOC:   jump = flags.alloc;
         hfc_pkg::COND_NO_BACK: jump = flags.no_back;
         default:               jump = 1'b0;
      endcase

      // a taken branch suppresses the rest of the step
      exec = busy_ff && !jump;

      case (hfc_pkg::oper_type'(operation))
         hfc_pkg::OPER_WRITE: entry = hfc_pkg::PC_WRITE;
         hfc_pkg::OPER_READ:  entry = hfc_pkg::PC_READ;
         hfc_pkg::OPER_FREE:  entry = hfc_pkg::PC_FREE;
         default:             entry = hfc_pkg::PC_NOP;
      endcase

      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (load) begin
         pc_in   = entry;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (jump) begin
            pc_in = uw.target;
         end else begin
            pc_in = pc_ff + hfc_pkg::PC_W'(1);
         end
         if (exec && uw.fin != hfc_pkg::FIN_NONE) begin
            busy_in = 1'b0;
         end
      end

      ctrl.load = load;
      ctrl.rd   = exec && uw.rd;
      ctrl.wr   = exec && uw.wr;
      ctrl.asel = uw.asel;
      ctrl.wsel = uw.wsel;
      ctrl.op   = exec ? uw.op : hfc_pkg::OP_NONE;
      ctrl.fin  = exec ? uw.fin : hfc_pkg::FIN_NONE;
   end

   assign busy = busy_ff;

   `HFC_ASSERT_NEXT(a_busy_after_start, start && !busy_ff, busy_ff, "start did not raise busy")
   `HFC_ASSERT_NEXT(a_idle_after_finish, ctrl.fin != hfc_pkg::FIN_NONE, !busy_ff, "finish did not end transaction")
   `HFC_ASSERT_IMPL(a_no_access_idle, !busy_ff, !ctrl.rd && !ctrl.wr, "heap access while idle")

endmodule

// ----- sv/hfc_dpath.sv -----
`timescale 1ns / 1ps
`include "heap_free_coalesce_assert.svh"

module hfc_dpath (
   input  logic                       clock,
   input  logic                       reset,
   input  hfc_pkg::req_type           req_item,
   input  hfc_pkg::ctrl_type          ctrl,
   input  logic                       csr_we,
   input  logic [hfc_pkg::OFF_W-1:0]  csr_data,
   output hfc_pkg::flags_type         flags,
   output logic                       rsp_valid,
   output hfc_pkg::rsp_type           rsp_item
);

   logic [hfc_pkg::OFF_W-1:0] blk_ff, blk_in;
   logic [hfc_pkg::OFF_W-1:0] aux_ff, aux_in;
   logic [hfc_pkg::OFF_W-1:0] first_ff;
   logic [63:0]               size_ff, size_in;
   logic [63:0]               psize_ff, psize_in;
   logic                      pbit_ff, pbit_in;
   logic [63:0]               data_ff, data_in;
   logic                      rsp_valid_ff;
   hfc_pkg::rsp_type          rsp_ff, rsp_in;

   logic [hfc_pkg::OFF_W-1:0]   addr;
   logic [hfc_pkg::WORD_AW-1:0] word;
   logic [63:0]                 wdata;
   logic [63:0]                 rdata;
   logic [63:0]                 rsize;
   logic [hfc_pkg::OFF_W-1:0]   tag_off;

   assign tag_off = hfc_pkg::OFF_W'(hfc_pkg::TAG_BYTES);
   assign rsize   = rdata & hfc_pkg::SIZE_MASK;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            first_ff <= csr_data;
         end
         rsp_valid_ff <= ctrl.fin != hfc_pkg::FIN_NONE;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff   <= blk_in;
      aux_ff   <= aux_in;
      size_ff  <= size_in;
      psize_ff <= psize_in;
      pbit_ff  <= pbit_in;
      data_ff  <= data_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      case (ctrl.asel)
         hfc_pkg::ASEL_BLK:   addr = blk_ff;
         hfc_pkg::ASEL_AUX:   addr = aux_ff;
         hfc_pkg::ASEL_FOOT:  addr = blk_ff + size_ff[hfc_pkg::OFF_W-1:0] - tag_off;
         hfc_pkg::ASEL_PFOOT: addr = blk_ff - tag_off;
         default:             addr = blk_ff;
      endcase
      word = hfc_pkg::word_index(addr);

      case (ctrl.wsel)
         hfc_pkg::WSEL_DATA:      wdata = data_ff;
         hfc_pkg::WSEL_CLR_ALLOC: wdata = rdata & ~64'd1;
         hfc_pkg::WSEL_SIZE:      wdata = size_ff;
         hfc_pkg::WSEL_TAG_RD:    wdata = size_ff | {62'd0, rdata[1], 1'b0};
         hfc_pkg::WSEL_TAG_PREV:  wdata = size_ff | {62'd0, pbit_ff, 1'b0};
         hfc_pkg::WSEL_CLR_PREV:  wdata = rdata & ~64'd2;
         default:                 wdata = data_ff;
      endcase
   end

   always_comb begin
      blk_in   = blk_ff;
      aux_in   = aux_ff;
      size_in  = size_ff;
      psize_in = psize_ff;
      pbit_in  = pbit_ff;
      data_in  = data_ff;

      if (ctrl.load) begin
         blk_in  = req_item.address - tag_off;
         aux_in  = req_item.address;
         data_in = req_item.data;
      end

      case (ctrl.op)
         hfc_pkg::OP_NONE: begin
         end
         hfc_pkg::OP_LOAD_SIZE: size_in = rsize;
         hfc_pkg::OP_NEXT_PTR:  aux_in = blk_ff + size_ff[hfc_pkg::OFF_W-1:0];
         hfc_pkg::OP_ADD_NEXT:  size_in = size_ff + rsize;
         hfc_pkg::OP_PREV_PTR:  aux_in = blk_ff - rdata[hfc_pkg::OFF_W-1:0];
         hfc_pkg::OP_LOAD_PREV: begin
            psize_in = rsize;
            pbit_in  = rdata[1];
         end
         hfc_pkg::OP_MERGE_PREV: begin
            size_in = psize_ff + rsize;
            blk_in  = aux_ff;
         end
         hfc_pkg::OP_FINAL_PTR: aux_in = blk_ff + rsize[hfc_pkg::OFF_W-1:0];
         default: begin
         end
      endcase

      rsp_in = '0;
      case (ctrl.fin)
         hfc_pkg::FIN_READ:   rsp_in.read_data = rdata;
         hfc_pkg::FIN_IGNORE: rsp_in.status = 1'b1;
         hfc_pkg::FIN_FREE: begin
            rsp_in.merged_block_offset = blk_ff;
            rsp_in.merged_block_size   = (size_ff[63:16] != '0) ? 16'hFFFF : size_ff[15:0];
         end
         default: rsp_in = '0;
      endcase
   end

   hfc_ram #(
      .WIDTH(64),
      .DEPTH(hfc_pkg::HEAP_WORDS)
   ) u_heap (
      .clock   (clock),
      .wr_en   (ctrl.wr),
      .wr_addr (word),
      .wr_data (wdata),
      .rd_en   (ctrl.rd),
      .rd_addr (word),
      .rd_data (rdata)
   );

   assign flags.null_addr = aux_ff == '0;
   assign flags.alloc     = rdata[0];
   assign flags.no_back   = rdata[1] || (blk_ff == first_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `HFC_ASSERT_NEXT(a_strobe_single, rsp_valid_ff, !rsp_valid_ff, "result strobe longer than one cycle")
   `HFC_ASSERT_IMPL(a_ignore_no_block, rsp_valid_ff && rsp_ff.status, rsp_ff.merged_block_offset == '0 && rsp_ff.merged_block_size == '0, "ignored free reports a block")

endmodule

// ----- sv/heap_free_coalesce.sv -----
`timescale 1ns / 1ps
// the result strobe rises once the microcode program for the operation has run: write, read
// and unused code run short programs; a free ends early when null or not allocated, else it runs the merges taken
// at most one heap memory access per microcode step sets the free time; busy drops as the
// result strobe rises, so a new transaction can start while the result strobe is shown
// synchronous reset clears the sequencer, result strobe and first block offset;
// heap memory contents are not cleared

module heap_free_coalesce (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  hfc_pkg::req_type           req_item,
   output logic                       rsp_valid,
   output hfc_pkg::rsp_type           rsp_item,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [hfc_pkg::OFF_W-1:0]  csr_data
);

   hfc_pkg::ctrl_type  ctrl;
   hfc_pkg::flags_type flags;
   logic               busy_int;

   hfc_useq u_useq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .operation (req_item.operation),
      .flags     (flags),
      .ctrl      (ctrl),
      .busy      (busy_int)
   );

   hfc_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .ctrl      (ctrl),
      .csr_we    (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .flags     (flags),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   assign busy      = busy_int;
   assign csr_ready = !busy_int;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import hfc_pkg::*;

   localparam logic [1:0]  OPER_UNUSED = 2'd3;
   localparam logic [63:0] ALLOC_BIT   = 64'h1;
   localparam logic [63:0] PREV_BIT    = 64'h2;
   localparam logic [63:0] TAG_LEN     = 64'(TAG_BYTES);
   localparam int          TOTAL_ITEMS = 1850;
   localparam int          FILL_WORDS  = 320;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_item;
   logic             rsp_valid;
   rsp_type          rsp_item;
   logic             csr_valid;
   logic             csr_ready;
   logic [OFF_W-1:0] csr_data;

   heap_free_coalesce uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // shadow copy of the heap and the first block register
   logic [63:0]      heap_img [HEAP_WORDS];
   bit               written [HEAP_WORDS];
   logic [OFF_W-1:0] first_blk;
   rsp_type          expect_q [$];

   // undo log for trial predictions
   bit               dry_run;
   bit               undef_hit;
   logic [WORD_AW-1:0] undo_idx [$];
   logic [63:0]      undo_val [$];
   bit               undo_wr [$];

   int idle_pct;
   int mismatches;
   int sent;
   int frees_done;
   int frees_ignored;
   int fwd_merges;
   int back_merges;
   int reads;
   int settings;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2500000;
      $display("** heap_free_coalesce: FAILED **");
      $finish;
   end

   function automatic logic [OFF_W-1:0] off_plus(input logic [OFF_W-1:0] a,
                                                 input logic [63:0] b);
      logic [63:0] s;
      s = 64'(a) + b;
      return s[OFF_W-1:0];
   endfunction

   function automatic logic [OFF_W-1:0] off_minus(input logic [OFF_W-1:0] a,
                                                  input logic [63:0] b);
      logic [63:0] s;
      s = 64'(a) - b;
      return s[OFF_W-1:0];
   endfunction

   function automatic logic [63:0] get_word(input logic [OFF_W-1:0] off);
      if (!written[off[OFF_W-1:3]])
         undef_hit = 1'b1;
      return heap_img[off[OFF_W-1:3]];
   endfunction

   function automatic void put_word(input logic [OFF_W-1:0] off, input logic [63:0] v);
      if (dry_run) begin
         undo_idx.push_back(off[OFF_W-1:3]);
         undo_val.push_back(heap_img[off[OFF_W-1:3]]);
         undo_wr.push_back(written[off[OFF_W-1:3]]);
      end
      heap_img[off[OFF_W-1:3]] = v;
      written[off[OFF_W-1:3]] = 1'b1;
   endfunction

   function automatic logic [63:0] make_tag(input logic [63:0] bytes, input bit alloc,
                                            input bit prev);
      return bytes | (alloc ? ALLOC_BIT : 64'h0) | (prev ? PREV_BIT : 64'h0);
   endfunction

   // tags are re-read at every step so overlapping tags behave in program order
   function automatic rsp_type free_and_merge(input logic [OFF_W-1:0] payload);
      rsp_type          r;
      logic [OFF_W-1:0] blk;
      logic [OFF_W-1:0] nxt;
      logic [OFF_W-1:0] prv;
      logic [63:0]      size;
      logic [63:0]      nsize;
      r = '0;
      blk = off_minus(payload, TAG_LEN);
      if (payload == '0) begin
         r.status = 1'b1;
         return r;
      end
      if ((get_word(blk) & ALLOC_BIT) == 64'h0) begin
         r.status = 1'b1;
         return r;
      end
      put_word(blk, get_word(blk) & ~ALLOC_BIT);
      size = get_word(blk) & SIZE_MASK;
      put_word(off_minus(off_plus(blk, size), TAG_LEN), size);
      nxt = off_plus(blk, size);
      if ((get_word(nxt) & ALLOC_BIT) == 64'h0) begin
         nsize = size + (get_word(nxt) & SIZE_MASK);
         put_word(blk, nsize | (get_word(blk) & PREV_BIT));
         put_word(off_minus(off_plus(blk, nsize), TAG_LEN), nsize);
         size = nsize;
         fwd_merges++;
      end
      if ((get_word(blk) & PREV_BIT) == 64'h0 && blk != first_blk) begin
         prv = off_minus(blk, get_word(off_minus(blk, TAG_LEN)));
         nsize = (get_word(prv) & SIZE_MASK) + (get_word(blk) & SIZE_MASK);
         put_word(prv, nsize | (get_word(prv) & PREV_BIT));
         put_word(off_minus(off_plus(prv, nsize), TAG_LEN), nsize);
         blk = prv;
         size = nsize;
         back_merges++;
      end
      nxt = off_plus(blk, get_word(blk) & SIZE_MASK);
      put_word(nxt, get_word(nxt) & ~PREV_BIT);
      r.merged_block_offset = blk;
      r.merged_block_size = (size > 64'hFFFF) ? 16'hFFFF : size[15:0];
      return r;
   endfunction

   function automatic rsp_type predict_item(input req_type it);
      rsp_type r;
      r = '0;
      case (it.operation)
         OPER_WRITE: put_word(it.address, it.data);
         OPER_READ:  r.read_data = get_word(it.address);
         OPER_FREE:  r = free_and_merge(it.address);
         default: ;
      endcase
      return r;
   endfunction

   // trial run of one transaction on the shadow heap, rolled back afterwards
   function automatic bit touches_undef(input req_type it);
      int fm;
      int bm;
      bit hit;
      fm = fwd_merges;
      bm = back_merges;
      undef_hit = 1'b0;
      dry_run = 1'b1;
      void'(predict_item(it));
      hit = undef_hit;
      while (undo_idx.size() != 0) begin
         heap_img[undo_idx[$]] = undo_val[$];
         written[undo_idx[$]] = undo_wr[$];
         void'(undo_idx.pop_back());
         void'(undo_val.pop_back());
         void'(undo_wr.pop_back());
      end
      dry_run = 1'b0;
      fwd_merges = fm;
      back_merges = bm;
      return hit;
   endfunction

   task automatic send_op(input logic [1:0] op, input logic [OFF_W-1:0] addr,
                          input logic [63:0] data);
      req_type it;
      rsp_type r;
      int      gap;
      it.operation = op;
      it.address = addr;
      it.data = data;
      // never let a transaction read heap words that were not written yet
      if (touches_undef(it))
         it.operation = OPER_WRITE;
      if ($urandom_range(99) < idle_pct) begin
         gap = $urandom_range(1, 3);
         if ($urandom_range(7) == 0)
            gap = gap + $urandom_range(24);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (busy);
      r = predict_item(it);
      expect_q.push_back(r);
      sent++;
      if (it.operation == OPER_READ)
         reads++;
      if (it.operation == OPER_FREE) begin
         if (r.status)
            frees_ignored++;
         else
            frees_done++;
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (expect_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_first_block(input logic [OFF_W-1:0] off);
      csr_valid <= 1'b1;
      csr_data <= off;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      first_blk = off;
      settings++;
   endtask

   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expect_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result with no transaction pending: data %h status %0d off %h size %h",
                        $realtime, rsp_item.read_data, rsp_item.status,
                        rsp_item.merged_block_offset, rsp_item.merged_block_size);
         end else begin
            want = expect_q.pop_front();
            if (rsp_item !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: mismatch exp data %h status %0d off %h size %h, got %h %0d %h %h",
                           $realtime, want.read_data, want.status, want.merged_block_offset,
                           want.merged_block_size, rsp_item.read_data, rsp_item.status,
                           rsp_item.merged_block_offset, rsp_item.merged_block_size);
            end
         end
      end
   end

   // low heap words used by the directed free cases
   task automatic test_fill_heap();
      for (int i = 0; i < FILL_WORDS; i++) begin
         if (i % 2 == 0)
            send_op(OPER_WRITE, OFF_W'(i * 8 + $urandom_range(7)),
                    make_tag(64'h10, 1'b1, 1'b1));
         else
            send_op(OPER_WRITE, OFF_W'(i * 8 + $urandom_range(7)), {$urandom, $urandom});
      end
   endtask

   task automatic test_word_access();
      send_op(OPER_READ, '0, '1);
      send_op(OPER_WRITE, 15'h7FF8, '1);
      send_op(OPER_READ, 15'h7FFF, '0);
      send_op(OPER_WRITE, 15'h0008, '0);
      send_op(OPER_UNUSED, 15'h7FFF, '1);
   endtask

   task automatic test_free_cases();
      // null and already free
      send_op(OPER_FREE, '0, '1);
      send_op(OPER_WRITE, 15'h0100, make_tag(64'h20, 1'b0, 1'b1));
      send_op(OPER_FREE, 15'h0108, '0);
      // plain free, no neighbor free
      send_op(OPER_WRITE, 15'h0200, make_tag(64'h20, 1'b1, 1'b1));
      send_op(OPER_FREE, 15'h0208, '0);
      // merge with next
      send_op(OPER_WRITE, 15'h0300, make_tag(64'h20, 1'b1, 1'b1));
      send_op(OPER_WRITE, 15'h0320, make_tag(64'h30, 1'b0, 1'b1));
      send_op(OPER_FREE, 15'h0308, '0);
      // merge with previous
      send_op(OPER_WRITE, 15'h0400, make_tag(64'h20, 1'b1, 1'b1));
      send_op(OPER_FREE, 15'h0408, '0);
      send_op(OPER_FREE, 15'h0428, '0);
      // merge both ways
      send_op(OPER_WRITE, 15'h0500, make_tag(64'h20, 1'b1, 1'b1));
      send_op(OPER_WRITE, 15'h0520, make_tag(64'h10, 1'b1, 1'b1));
      send_op(OPER_WRITE, 15'h0530, make_tag(64'h20, 1'b1, 1'b1));
      send_op(OPER_FREE, 15'h0508, '0);
      send_op(OPER_FREE, 15'h0538, '0);
      send_op(OPER_FREE, 15'h0528, '0);
      // first block with prev bit clear stays put
      send_op(OPER_WRITE, 15'h0000, make_tag(64'h10, 1'b1, 1'b0));
      send_op(OPER_FREE, 15'h0008, '0);
      // huge size saturates
      send_op(OPER_WRITE, 15'h0600, 64'hFFFF_FFFF_FFFF_FFF3);
      send_op(OPER_FREE, 15'h0608, '0);
      // block straddling the top of the heap
      send_op(OPER_WRITE, 15'h7FF0, make_tag(64'h20, 1'b1, 1'b1));
      send_op(OPER_FREE, 15'h7FF8, '0);
      // zero size tag, and payload offset with low bits set
      send_op(OPER_WRITE, 15'h0800, make_tag(64'h0, 1'b1, 1'b1));
      send_op(OPER_FREE, 15'h0808, '0);
      send_op(OPER_WRITE, 15'h0900, make_tag(64'h20, 1'b1, 1'b1));
      send_op(OPER_FREE, 15'h090B, '1);
   endtask

   // lay out a run of allocated blocks at the first block offset, then free them
   task automatic run_heap_round();
      logic [OFF_W-1:0] payloads [$];
      logic [OFF_W-1:0] base;
      logic [OFF_W-1:0] pos;
      logic [OFF_W-1:0] tmp;
      logic [63:0]      bsize;
      int               nblk;
      int               k;
      int               roll;
      wait_idle();
      case ($urandom_range(7))
         0: base = '0;
         1: base = 15'h7FF8;
         2: base = 15'h7FFF;
         default: base = OFF_W'($urandom);
      endcase
      write_first_block(base);
      pos = base;
      nblk = $urandom_range(3, 10);
      for (int j = 0; j < nblk; j++) begin
         if ($urandom_range(9) == 0)
            bsize = 64'(16 * $urandom_range(5, 64));
         else
            bsize = 64'(16 * $urandom_range(1, 4));
         send_op(OPER_WRITE, pos, make_tag(bsize, 1'b1, j != 0 || $urandom_range(1) == 1));
         payloads.push_back(off_plus(pos, TAG_LEN));
         if ($urandom_range(3) == 0)
            send_op(OPER_WRITE, off_plus(pos, TAG_LEN), {$urandom, $urandom});
         pos = off_plus(pos, bsize);
      end
      // end mark
      send_op(OPER_WRITE, pos, make_tag(64'h0, 1'b1, 1'b1));
      for (int j = payloads.size() - 1; j > 0; j--) begin
         k = $urandom_range(j);
         tmp = payloads[j];
         payloads[j] = payloads[k];
         payloads[k] = tmp;
      end
      for (int j = 0; j < payloads.size(); j++) begin
         roll = $urandom_range(99);
         if (roll < 20)
            send_op(OPER_READ, off_minus(payloads[$urandom_range(payloads.size() - 1)],
                    TAG_LEN), {$urandom, $urandom});
         else if (roll < 28)
            send_op(OPER_FREE, payloads[$urandom_range(j)], {$urandom, $urandom});
         else if (roll < 33)
            send_op(2'($urandom_range(3)), OFF_W'($urandom), {$urandom, $urandom});
         else if (roll < 36)
            send_op(OPER_FREE, OFF_W'($urandom), {$urandom, $urandom});
         send_op(OPER_FREE, payloads[j], {$urandom, $urandom});
      end
   endtask

   task automatic test_heap_rounds();
      int first_sent;
      int span;
      first_sent = sent;
      span = TOTAL_ITEMS - first_sent;
      while (sent < TOTAL_ITEMS) begin
         if (sent - first_sent < span / 3)
            idle_pct = 6;
         else if (sent - first_sent < 2 * span / 3)
            idle_pct = 48;
         else
            idle_pct = 0;
         run_heap_round();
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      first_blk = '0;
      dry_run = 1'b0;
      undef_hit = 1'b0;
      idle_pct = 6;
      mismatches = 0;
      sent = 0;
      frees_done = 0;
      frees_ignored = 0;
      fwd_merges = 0;
      back_merges = 0;
      reads = 0;
      settings = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_fill_heap();
      test_word_access();
      test_free_cases();
      test_heap_rounds();
      wait_idle();
      repeat (30) @(posedge clock);
      $display("covered %0d transactions: %0d frees done (%0d forward, %0d backward merges)",
               sent, frees_done, fwd_merges, back_merges);
      $display("also %0d ignored frees, %0d word reads, %0d first block settings, %0d mismatches",
               frees_ignored, reads, settings, mismatches);
      if (mismatches == 0)
         $display("** heap_free_coalesce: PASSED **");
      else
         $display("** heap_free_coalesce: FAILED **");
      $finish;
   end

endmodule

// ----- heap_free_coalesce.f -----
+incdir+sv
sv/hfc_pkg.sv
sv/hfc_ram.sv
sv/hfc_useq.sv
sv/hfc_dpath.sv
sv/heap_free_coalesce.sv
sim/testbench.sv
